FILE: sv/pmrp_pkg.sv
// shared types and constants for the point-in-mesh ray parity block
// no dependencies
`default_nettype none
package pmrp_pkg;

    localparam int SLOT_W   = 11;
    localparam int CORNER_W = 10;
    localparam int VCNT_W   = 11;
    localparam int FCNT_W   = 12;
    localparam int CFG_W    = 12;
    localparam int QDEPTH   = 4;
    localparam int QAW      = 2;

    typedef enum logic [1:0] {
        FUNC_VERTEX   = 2'd0,
        FUNC_TRIANGLE = 2'd1,
        FUNC_QUERY    = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    typedef enum logic [0:0] {
        REG_VERTEX_COUNT = 1'b0,
        REG_FACE_COUNT   = 1'b1
    } reg_idx_t;

    // one queued item between front and back
    typedef struct packed {
        func_t                kind;
        logic [SLOT_W-1:0]    slot;
        logic [CORNER_W-1:0]  ca;
        logic [CORNER_W-1:0]  cb;
        logic [CORNER_W-1:0]  cc;
    } item_t;

endpackage
`default_nettype wire

FILE: sv/pmrp_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none
module pmrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: sv/pmrp_front.sv
// front end: accepts items, drops the ones that do nothing, queues the rest
// depends on pmrp_pkg
`default_nettype none
module pmrp_front import pmrp_pkg::*; #(
    parameter int COORD_BITS    = 24,
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_TRIANGLES = 2048
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic [1:0]              func,
    input  wire logic [SLOT_W-1:0]       slot,
    input  wire logic [COORD_BITS-1:0]   coord_x,
    input  wire logic [COORD_BITS-1:0]   coord_y,
    input  wire logic [COORD_BITS-1:0]   coord_z,
    input  wire logic [CORNER_W-1:0]     corner_a,
    input  wire logic [CORNER_W-1:0]     corner_b,
    input  wire logic [CORNER_W-1:0]     corner_c,
    input  wire logic                    q_pop,
    output logic                         q_empty,
    output item_t                        q_item,
    output logic [3*COORD_BITS-1:0]      q_point
);

    item_t                   item_mem_reg [QDEPTH];
    logic [3*COORD_BITS-1:0] pt_mem_reg   [QDEPTH];
    logic [QAW-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]            cnt_reg, cnt_next;
    logic                    keep;
    logic                    wr;
    logic                    rd;
    func_t                   kind;
    item_t                   new_item;

    assign kind = func_t'(func);

    always_comb
    begin
        unique case (kind)
            FUNC_VERTEX:   keep = 32'(slot) < 32'(MAX_VERTICES);
            FUNC_TRIANGLE: keep = 32'(slot) < 32'(MAX_TRIANGLES);
            FUNC_QUERY:    keep = 1'b1;
            default:       keep = 1'b0;
        endcase
    end

    assign full    = (cnt_reg == (QAW+1)'(QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign wr      = push && !full && keep;
    assign rd      = q_pop && !q_empty;

    assign new_item.kind = kind;
    assign new_item.slot = slot;
    assign new_item.ca   = corner_a;
    assign new_item.cb   = corner_b;
    assign new_item.cc   = corner_c;

    assign wr_ptr_next = wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign cnt_next    = cnt_reg + (QAW+1)'(wr) - (QAW+1)'(rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            item_mem_reg[wr_ptr_reg] <= new_item;
            pt_mem_reg[wr_ptr_reg]   <= {coord_z, coord_y, coord_x};
        end
    end

    assign q_item  = item_mem_reg[rd_ptr_reg];
    assign q_point = pt_mem_reg[rd_ptr_reg];

endmodule
`default_nettype wire

FILE: sv/pmrp_geom.sv
// pipelined ray/triangle crossing test, one triangle per cycle
// depends on pmrp_pkg (import only for house style)
`default_nettype none
module pmrp_geom import pmrp_pkg::*; #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic                    in_skip,
    input  wire logic [3*COORD_BITS-1:0] point,
    input  wire logic [3*COORD_BITS-1:0] va,
    input  wire logic [3*COORD_BITS-1:0] vb,
    input  wire logic [3*COORD_BITS-1:0] vc,
    output logic                         hit_valid,
    output logic                         hit,
    output logic                         busy
);

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int P  = 2 * D;
    localparam int NB = P + 1;
    localparam int NL = NB / 2;
    localparam int NH = NB - NL;
    localparam int LW = NL + 1 + D;
    localparam int HW = NH + D;
    localparam int TW = NB + D;
    localparam int DW = TW + 2;

    logic signed [C-1:0] px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz;
    assign px = signed'(point[C-1:0]);
    assign py = signed'(point[2*C-1:C]);
    assign pz = signed'(point[3*C-1:2*C]);
    assign ax = signed'(va[C-1:0]);
    assign ay = signed'(va[2*C-1:C]);
    assign az = signed'(va[3*C-1:2*C]);
    assign bx = signed'(vb[C-1:0]);
    assign by = signed'(vb[2*C-1:C]);
    assign bz = signed'(vb[3*C-1:2*C]);
    assign cx = signed'(vc[C-1:0]);
    assign cy = signed'(vc[2*C-1:C]);
    assign cz = signed'(vc[3*C-1:2*C]);

    // stage 1: edges and offset
    logic              g1_v_reg, g1_skip_reg;
    logic signed [D-1:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [D-1:0] g1_wx_reg, g1_wy_reg, g1_wz_reg;
    // stage 2: products
    logic              g2_v_reg, g2_skip_reg;
    logic signed [P-1:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [P-1:0] m5_reg, m6_reg, m7_reg, m8_reg, m9_reg;
    logic signed [D-1:0] g2_wx_reg, g2_wy_reg, g2_wz_reg;
    // stage 3: normal and barycentric numerators
    logic              g3_v_reg, g3_skip_reg;
    logic signed [NB-1:0] g3_nx_reg, g3_ny_reg, g3_nz_reg, g3_ap_reg, g3_bp_reg;
    logic signed [D-1:0]  g3_wx_reg, g3_wy_reg, g3_wz_reg;
    // stage 4: split products of normal and offset
    logic              g4_v_reg, g4_skip_reg;
    logic signed [LW-1:0] lox_reg, loy_reg, loz_reg;
    logic signed [HW-1:0] hix_reg, hiy_reg, hiz_reg;
    logic signed [NB-1:0] g4_nx_reg, g4_ap_reg, g4_bp_reg;
    // stage 5: per-axis terms
    logic              g5_v_reg, g5_skip_reg;
    logic signed [TW-1:0] tx_reg, ty_reg, tz_reg;
    logic signed [NB-1:0] g5_nx_reg, g5_ap_reg, g5_bp_reg;
    // stage 6: dot product
    logic              g6_v_reg, g6_skip_reg;
    logic signed [DW-1:0] dot_reg;
    logic signed [NB-1:0] g6_nx_reg, g6_ap_reg, g6_bp_reg;
    // stage 7: decision
    logic              hit_valid_reg, hit_reg;

    logic signed [NB:0]   sum_ab;
    logic                 nx_pos, dot_neg, dot_pos, hit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_v_reg      <= 1'b0;
            g2_v_reg      <= 1'b0;
            g3_v_reg      <= 1'b0;
            g4_v_reg      <= 1'b0;
            g5_v_reg      <= 1'b0;
            g6_v_reg      <= 1'b0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            g1_v_reg      <= in_valid;
            g2_v_reg      <= g1_v_reg;
            g3_v_reg      <= g2_v_reg;
            g4_v_reg      <= g3_v_reg;
            g5_v_reg      <= g4_v_reg;
            g6_v_reg      <= g5_v_reg;
            hit_valid_reg <= g6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        g1_skip_reg <= in_skip;
        e1x_reg     <= D'(bx) - D'(ax);
        e1y_reg     <= D'(by) - D'(ay);
        e1z_reg     <= D'(bz) - D'(az);
        e2x_reg     <= D'(cx) - D'(ax);
        e2y_reg     <= D'(cy) - D'(ay);
        e2z_reg     <= D'(cz) - D'(az);
        g1_wx_reg   <= D'(px) - D'(ax);
        g1_wy_reg   <= D'(py) - D'(ay);
        g1_wz_reg   <= D'(pz) - D'(az);

        g2_skip_reg <= g1_skip_reg;
        m0_reg      <= P'(e1y_reg) * P'(e2z_reg);
        m1_reg      <= P'(e1z_reg) * P'(e2y_reg);
        m2_reg      <= P'(e1z_reg) * P'(e2x_reg);
        m3_reg      <= P'(e1x_reg) * P'(e2z_reg);
        m4_reg      <= P'(e1x_reg) * P'(e2y_reg);
        m5_reg      <= P'(e1y_reg) * P'(e2x_reg);
        m6_reg      <= P'(g1_wy_reg) * P'(e2z_reg);
        m7_reg      <= P'(g1_wz_reg) * P'(e2y_reg);
        m8_reg      <= P'(e1y_reg) * P'(g1_wz_reg);
        m9_reg      <= P'(e1z_reg) * P'(g1_wy_reg);
        g2_wx_reg   <= g1_wx_reg;
        g2_wy_reg   <= g1_wy_reg;
        g2_wz_reg   <= g1_wz_reg;

        g3_skip_reg <= g2_skip_reg;
        g3_nx_reg   <= NB'(m0_reg) - NB'(m1_reg);
        g3_ny_reg   <= NB'(m2_reg) - NB'(m3_reg);
        g3_nz_reg   <= NB'(m4_reg) - NB'(m5_reg);
        g3_ap_reg   <= NB'(m6_reg) - NB'(m7_reg);
        g3_bp_reg   <= NB'(m8_reg) - NB'(m9_reg);
        g3_wx_reg   <= g2_wx_reg;
        g3_wy_reg   <= g2_wy_reg;
        g3_wz_reg   <= g2_wz_reg;

        // normal parallel to the ray or degenerate triangle counts as a miss
        g4_skip_reg <= g3_skip_reg || (g3_nx_reg == '0);
        lox_reg     <= LW'(signed'({1'b0, g3_nx_reg[NL-1:0]})) * LW'(g3_wx_reg);
        loy_reg     <= LW'(signed'({1'b0, g3_ny_reg[NL-1:0]})) * LW'(g3_wy_reg);
        loz_reg     <= LW'(signed'({1'b0, g3_nz_reg[NL-1:0]})) * LW'(g3_wz_reg);
        hix_reg     <= HW'(signed'(g3_nx_reg[NB-1:NL])) * HW'(g3_wx_reg);
        hiy_reg     <= HW'(signed'(g3_ny_reg[NB-1:NL])) * HW'(g3_wy_reg);
        hiz_reg     <= HW'(signed'(g3_nz_reg[NB-1:NL])) * HW'(g3_wz_reg);
        g4_nx_reg   <= g3_nx_reg;
        g4_ap_reg   <= g3_ap_reg;
        g4_bp_reg   <= g3_bp_reg;

        g5_skip_reg <= g4_skip_reg;
        tx_reg      <= (TW'(hix_reg) <<< NL) + TW'(lox_reg);
        ty_reg      <= (TW'(hiy_reg) <<< NL) + TW'(loy_reg);
        tz_reg      <= (TW'(hiz_reg) <<< NL) + TW'(loz_reg);
        g5_nx_reg   <= g4_nx_reg;
        g5_ap_reg   <= g4_ap_reg;
        g5_bp_reg   <= g4_bp_reg;

        g6_skip_reg <= g5_skip_reg;
        dot_reg     <= DW'(tx_reg) + DW'(ty_reg) + DW'(tz_reg);
        g6_nx_reg   <= g5_nx_reg;
        g6_ap_reg   <= g5_ap_reg;
        g6_bp_reg   <= g5_bp_reg;

        hit_reg     <= hit_next;
    end

    // distance is -dot/nx, so its sign flips with the normal
    always_comb
    begin
        sum_ab  = (NB+1)'(g6_ap_reg) + (NB+1)'(g6_bp_reg);
        nx_pos  = !g6_nx_reg[NB-1];
        dot_neg = dot_reg[DW-1];
        dot_pos = !dot_reg[DW-1] && (dot_reg != '0);
        if (nx_pos)
        begin
            hit_next = dot_neg && !g6_ap_reg[NB-1] && !g6_bp_reg[NB-1]
                       && (sum_ab <= (NB+1)'(g6_nx_reg));
        end
        else
        begin
            hit_next = dot_pos && (g6_ap_reg[NB-1] || (g6_ap_reg == '0))
                       && (g6_bp_reg[NB-1] || (g6_bp_reg == '0))
                       && (sum_ab >= (NB+1)'(g6_nx_reg));
        end
        hit_next = hit_next && !g6_skip_reg;
    end

    assign hit_valid = hit_valid_reg;
    assign hit       = hit_reg;
    assign busy      = g1_v_reg || g2_v_reg || g3_v_reg || g4_v_reg
                       || g5_v_reg || g6_v_reg || hit_valid_reg;

endmodule
`default_nettype wire

FILE: sv/pmrp_back.sv
// back end: writes the stores, walks the triangles for a query, holds the result
// depends on pmrp_pkg, pmrp_ram, pmrp_geom
`default_nettype none
module pmrp_back import pmrp_pkg::*; #(
    parameter int COORD_BITS    = 24,
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_TRIANGLES = 2048
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_empty,
    input  wire item_t                   q_item,
    input  wire logic [3*COORD_BITS-1:0] q_point,
    output logic                         q_pop,
    input  wire logic [VCNT_W-1:0]       vertex_count,
    input  wire logic [FCNT_W-1:0]       face_count,
    output logic                         res_valid,
    output logic                         res_inside,
    output logic [FCNT_W-1:0]            res_crossings,
    input  wire logic                    res_pop
);

    localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int VW  = 3 * COORD_BITS;
    localparam int TRW = 3 * CORNER_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_SPARE = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [FCNT_W-1:0]   f_reg, f_next;
    logic [FCNT_W-1:0]   tally_reg, tally_next;
    logic [VW-1:0]       point_reg;
    logic                v1_reg, v2_reg, skip2_reg;
    logic                res_valid_reg, res_valid_next;
    logic                res_inside_reg;
    logic [FCNT_W-1:0]   res_cnt_reg;
    logic [VCNT_W-1:0]   nv;
    logic [FCNT_W-1:0]   nf;
    logic                issue, start_query, finish;
    logic                we_vtx, we_tri;
    logic [31:0]         slot_ext, f_ext, ca_ext, cb_ext, cc_ext;
    logic [TRW-1:0]      tri_rdata;
    logic [CORNER_W-1:0] ra, rb, rc;
    logic                skip1;
    logic [VW-1:0]       va_data, vb_data, vc_data;
    logic                hit_valid, hit, geom_busy, busy;

    assign nv = (32'(vertex_count) < 32'(MAX_VERTICES)) ? vertex_count
                                                        : VCNT_W'(MAX_VERTICES);
    assign nf = (32'(face_count) < 32'(MAX_TRIANGLES)) ? face_count
                                                       : FCNT_W'(MAX_TRIANGLES);

    assign q_pop       = (state_reg == ST_IDLE) && !q_empty;
    assign we_vtx      = q_pop && (q_item.kind == FUNC_VERTEX);
    assign we_tri      = q_pop && (q_item.kind == FUNC_TRIANGLE);
    assign start_query = q_pop && (q_item.kind == FUNC_QUERY);
    assign issue       = (state_reg == ST_WALK);
    assign busy        = v1_reg || v2_reg || geom_busy;
    assign finish      = (state_reg == ST_DRAIN) && !busy && !res_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        f_next     = f_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_query)
                begin
                    f_next     = '0;
                    state_next = (nf == '0) ? ST_DRAIN : ST_WALK;
                end
            end
            ST_WALK:
            begin
                f_next = f_reg + 1'b1;
                if (f_reg == nf - 1'b1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        tally_next = tally_reg;
        if (start_query)
        begin
            tally_next = '0;
        end
        else if (hit_valid && hit)
        begin
            tally_next = tally_reg + 1'b1;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end
        if (finish)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            f_reg         <= '0;
            tally_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            f_reg         <= f_next;
            tally_reg     <= tally_next;
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_query)
        begin
            point_reg <= q_point;
        end
        skip2_reg <= skip1;
        if (finish)
        begin
            res_inside_reg <= tally_reg[0];
            res_cnt_reg    <= tally_reg;
        end
    end

    assign slot_ext = 32'(q_item.slot);
    assign f_ext    = 32'(f_reg);

    pmrp_ram #(.WIDTH(TRW), .DEPTH(MAX_TRIANGLES)) u_tri_ram (
        .clk   (clk),
        .we    (we_tri),
        .waddr (slot_ext[TAW-1:0]),
        .wdata ({q_item.cc, q_item.cb, q_item.ca}),
        .re    (issue),
        .raddr (f_ext[TAW-1:0]),
        .rdata (tri_rdata)
    );

    assign ra     = tri_rdata[CORNER_W-1:0];
    assign rb     = tri_rdata[2*CORNER_W-1:CORNER_W];
    assign rc     = tri_rdata[3*CORNER_W-1:2*CORNER_W];
    assign ca_ext = 32'(ra);
    assign cb_ext = 32'(rb);
    assign cc_ext = 32'(rc);
    // a corner past the vertices in use drops the triangle
    assign skip1  = (ca_ext >= 32'(nv)) || (cb_ext >= 32'(nv)) || (cc_ext >= 32'(nv));

    // three copies of the vertex store give three reads a cycle
    pmrp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vtx_ram_a (
        .clk   (clk),
        .we    (we_vtx),
        .waddr (slot_ext[VAW-1:0]),
        .wdata (q_point),
        .re    (v1_reg),
        .raddr (ca_ext[VAW-1:0]),
        .rdata (va_data)
    );

    pmrp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vtx_ram_b (
        .clk   (clk),
        .we    (we_vtx),
        .waddr (slot_ext[VAW-1:0]),
        .wdata (q_point),
        .re    (v1_reg),
        .raddr (cb_ext[VAW-1:0]),
        .rdata (vb_data)
    );

    pmrp_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vtx_ram_c (
        .clk   (clk),
        .we    (we_vtx),
        .waddr (slot_ext[VAW-1:0]),
        .wdata (q_point),
        .re    (v1_reg),
        .raddr (cc_ext[VAW-1:0]),
        .rdata (vc_data)
    );

    pmrp_geom #(.COORD_BITS(COORD_BITS)) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_skip   (skip2_reg),
        .point     (point_reg),
        .va        (va_data),
        .vb        (vb_data),
        .vc        (vc_data),
        .hit_valid (hit_valid),
        .hit       (hit),
        .busy      (geom_busy)
    );

    assign res_valid     = res_valid_reg;
    assign res_inside    = res_inside_reg;
    assign res_crossings = res_cnt_reg;

endmodule
`default_nettype wire

FILE: sv/point_in_mesh_ray_parity.sv
// Point-in-mesh test by ray parity along +X.
// Input channel (push/full): func 0 loads a vertex at slot, func 1 loads a
// triangle (corner_a/b/c) at slot, func 2 queries the point coord_x/y/z.
// Loads to a slot past the store and func 3 are taken and dropped.
// Result channel (empty/pop): one result per query, inside_res and crossings.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
// vertex_count, index 1 face_count; cfg_ready is always high.
// Items enter a 4-deep queue, so input is taken while a result waits.
// A query walks the triangles, issuing one triangle a cycle into a 9-deep
// read and test pipeline, then drains it before posting the result.
// The result register holds one result; while it is not popped the back end
// holds its next finished query and the queue fills, then full rises.
// Reset clears the queue, the result register and both counts; the stores
// are not cleared and hold nothing meaningful until loaded.
// depends on pmrp_pkg, pmrp_front, pmrp_back
`default_nettype none
module point_in_mesh_ray_parity import pmrp_pkg::*; #(
    parameter int MAX_VERTICES  = 1024,
    parameter int MAX_TRIANGLES = 2048,
    parameter int COORD_BITS    = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [1:0]            func,
    input  wire logic [SLOT_W-1:0]     slot,
    input  wire logic [COORD_BITS-1:0] coord_x,
    input  wire logic [COORD_BITS-1:0] coord_y,
    input  wire logic [COORD_BITS-1:0] coord_z,
    input  wire logic [CORNER_W-1:0]   corner_a,
    input  wire logic [CORNER_W-1:0]   corner_b,
    input  wire logic [CORNER_W-1:0]   corner_c,
    output logic                       empty,
    input  wire logic                  pop,
    output logic                       inside_res,
    output logic [FCNT_W-1:0]          crossings,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [0:0]            cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    logic [VCNT_W-1:0]       vcount_reg;
    logic [FCNT_W-1:0]       fcount_reg;
    logic                    q_pop, q_empty, res_valid;
    item_t                   q_item;
    logic [3*COORD_BITS-1:0] q_point;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
            fcount_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_VERTEX_COUNT: vcount_reg <= cfg_data[VCNT_W-1:0];
                REG_FACE_COUNT:   fcount_reg <= cfg_data[FCNT_W-1:0];
                default:          vcount_reg <= vcount_reg;
            endcase
        end
    end

    pmrp_front #(
        .COORD_BITS    (COORD_BITS),
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .func     (func),
        .slot     (slot),
        .coord_x  (coord_x),
        .coord_y  (coord_y),
        .coord_z  (coord_z),
        .corner_a (corner_a),
        .corner_b (corner_b),
        .corner_c (corner_c),
        .q_pop    (q_pop),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_point  (q_point)
    );

    pmrp_back #(
        .COORD_BITS    (COORD_BITS),
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (q_item),
        .q_point       (q_point),
        .q_pop         (q_pop),
        .vertex_count  (vcount_reg),
        .face_count    (fcount_reg),
        .res_valid     (res_valid),
        .res_inside    (inside_res),
        .res_crossings (crossings),
        .res_pop       (pop)
    );

    assign empty = !res_valid;

endmodule
`default_nettype wire

FILE: sv/pmrp_checker.sv
// port-level checks for point_in_mesh_ray_parity, bound to the top level
// depends on pmrp_pkg and point_in_mesh_ray_parity
`default_nettype none
module pmrp_checker import pmrp_pkg::*; (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              empty,
    input wire logic              pop,
    input wire logic              inside_res,
    input wire logic [FCNT_W-1:0] crossings
);

    // parity flag matches the reported count whenever a result is waiting
    a_parity: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> inside_res == crossings[0])
        else $error("inside_res disagrees with crossings parity");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result dropped without pop");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(crossings) && $stable(inside_res))
        else $error("waiting result changed");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result present right after reset");

endmodule

bind point_in_mesh_ray_parity pmrp_checker u_pmrp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .inside_res (inside_res),
    .crossings  (crossings)
);
`default_nettype wire

FILE: tb/tb_point_in_mesh_ray_parity.sv
// testbench for point_in_mesh_ray_parity: loads meshes, casts query rays, checks crossings
// predicts each query with its own exact-integer ray/triangle test; needs pmrp_pkg and the rtl
`timescale 1ns / 1ps
module tb_point_in_mesh_ray_parity;
    import pmrp_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [23:0]  coord_t;

    typedef struct {
        func_t               kind;
        logic [SLOT_W-1:0]   slot;
        coord_t              x, y, z;
        logic [CORNER_W-1:0] a, b, c;
    } mesh_item_t;

    typedef struct {
        logic              odd;
        logic [FCNT_W-1:0] count;
    } parity_t;

    logic clk = 0;
    logic rst_n = 0;
    logic push = 0;
    logic [1:0] func = 0;
    logic [SLOT_W-1:0] slot = 0;
    logic [23:0] coord_x = 0, coord_y = 0, coord_z = 0;
    logic [CORNER_W-1:0] corner_a = 0, corner_b = 0, corner_c = 0;
    logic pop = 0;
    logic cfg_valid = 0;
    logic [0:0] cfg_index = 0;
    logic [CFG_W-1:0] cfg_data = 0;
    logic full, empty, inside_res, cfg_ready;
    logic [FCNT_W-1:0] crossings;

    point_in_mesh_ray_parity dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .func(func), .slot(slot),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
        .empty(empty), .pop(pop), .inside_res(inside_res), .crossings(crossings),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // predictor state
    coord_t mesh_vx [1024], mesh_vy [1024], mesh_vz [1024];
    logic [CORNER_W-1:0] tri_a [2048], tri_b [2048], tri_c [2048];
    int unsigned vert_limit = 0, face_limit = 0;

    mesh_item_t pending_items[$];
    parity_t    expected_parity[$];
    int errors = 0;
    bit calm = 0;
    bit hold_send = 0;
    int hold_pop = 0;

    function automatic bit ray_crosses(coord_t px, coord_t py, coord_t pz, int ia, int ib,
                                       int ic);
        wide_t e1x, e1y, e1z, e2x, e2y, e2z, wx, wy, wz, nx, ny, nz, ta, aa, bb, absn;
        e1x = wide_t'(mesh_vx[ib]) - wide_t'(mesh_vx[ia]);
        e1y = wide_t'(mesh_vy[ib]) - wide_t'(mesh_vy[ia]);
        e1z = wide_t'(mesh_vz[ib]) - wide_t'(mesh_vz[ia]);
        e2x = wide_t'(mesh_vx[ic]) - wide_t'(mesh_vx[ia]);
        e2y = wide_t'(mesh_vy[ic]) - wide_t'(mesh_vy[ia]);
        e2z = wide_t'(mesh_vz[ic]) - wide_t'(mesh_vz[ia]);
        wx = wide_t'(px) - wide_t'(mesh_vx[ia]);
        wy = wide_t'(py) - wide_t'(mesh_vy[ia]);
        wz = wide_t'(pz) - wide_t'(mesh_vz[ia]);
        nx = e1y * e2z - e1z * e2y;
        if (nx == 0)
            return 0;
        ny = e1z * e2x - e1x * e2z;
        nz = e1x * e2y - e1y * e2x;
        ta = -(nx * wx + ny * wy + nz * wz);
        aa = wy * e2z - wz * e2y;
        bb = e1y * wz - e1z * wy;
        absn = nx;
        if (nx < 0)
        begin
            ta = -ta;
            aa = -aa;
            bb = -bb;
            absn = -nx;
        end
        return ta > 0 && aa >= 0 && bb >= 0 && aa + bb <= absn;
    endfunction

    function automatic void apply_item(mesh_item_t it);
        int unsigned nv, nf, hits;
        parity_t r;
        nv = vert_limit > 1024 ? 1024 : vert_limit;
        nf = face_limit > 2048 ? 2048 : face_limit;
        hits = 0;
        case (it.kind)
            FUNC_VERTEX:
                if (it.slot < 1024)
                begin
                    mesh_vx[it.slot] = it.x;
                    mesh_vy[it.slot] = it.y;
                    mesh_vz[it.slot] = it.z;
                end
            FUNC_TRIANGLE:
            begin
                tri_a[it.slot] = it.a;
                tri_b[it.slot] = it.b;
                tri_c[it.slot] = it.c;
            end
            FUNC_QUERY:
            begin
                for (int f = 0; f < nf; f++)
                    if (tri_a[f] < nv && tri_b[f] < nv && tri_c[f] < nv &&
                        ray_crosses(it.x, it.y, it.z, tri_a[f], tri_b[f], tri_c[f]))
                        hits++;
                r.odd = hits[0];
                r.count = hits > 4095 ? 12'd4095 : hits[11:0];
                expected_parity.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (push && !full)
        begin
            apply_item(pending_items[0]);
            void'(pending_items.pop_front());
        end
        if (pending_items.size() > 0 && !hold_send && (calm || $urandom_range(99) >= 35))
        begin
            push <= 1;
            func <= pending_items[0].kind;
            slot <= pending_items[0].slot;
            coord_x <= pending_items[0].x;
            coord_y <= pending_items[0].y;
            coord_z <= pending_items[0].z;
            corner_a <= pending_items[0].a;
            corner_b <= pending_items[0].b;
            corner_c <= pending_items[0].c;
        end
        else
            push <= 0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            if (expected_parity.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                if (inside_res !== expected_parity[0].odd)
                begin
                    $error("inside_res expected %0d got %0d", expected_parity[0].odd,
                           inside_res);
                    errors++;
                end
                if (crossings !== expected_parity[0].count)
                begin
                    $error("crossings expected %0d got %0d", expected_parity[0].count,
                           crossings);
                    errors++;
                end
                void'(expected_parity.pop_front());
            end
        end
        if (hold_pop > 0)
        begin
            hold_pop <= hold_pop - 1;
            pop <= 0;
        end
        else
            pop <= calm || $urandom_range(99) >= 35;
    end

    function automatic coord_t rand_coord();
        if ($urandom_range(7) == 0)
            return coord_t'($urandom);
        return coord_t'(int'($urandom_range(32768)) - 16384);
    endfunction

    function automatic mesh_item_t make_item(func_t k, int s, coord_t x, coord_t y, coord_t z,
                                             int a, int b, int c);
        mesh_item_t it;
        it.kind = k;
        it.slot = SLOT_W'(s);
        it.x = x;
        it.y = y;
        it.z = z;
        it.a = CORNER_W'(a);
        it.b = CORNER_W'(b);
        it.c = CORNER_W'(c);
        return it;
    endfunction

    // waits until nothing is queued or outstanding, then lets trailing loads drain
    task automatic drain();
        while (pending_items.size() > 0 || push || expected_parity.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
        drain();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        if (idx == REG_VERTEX_COUNT)
            vert_limit = value[10:0];
        else
            face_limit = value;
    endtask

    task automatic random_phase(int n, int vc, int fc);
        int pick;
        mesh_item_t it;
        write_reg(REG_VERTEX_COUNT, CFG_W'(vc));
        write_reg(REG_FACE_COUNT, CFG_W'(fc));
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            it = make_item(FUNC_QUERY, $urandom_range(2047), rand_coord(), rand_coord(),
                           rand_coord(), $urandom_range(1023), $urandom_range(1023),
                           $urandom_range(1023));
            if (pick < 30)
            begin
                it.kind = FUNC_VERTEX;
                if ($urandom_range(4) != 0)
                    it.slot = SLOT_W'($urandom_range(63));
            end
            else if (pick < 55)
            begin
                it.kind = FUNC_TRIANGLE;
                // corners mostly inside the loaded vertices so crossings happen
                if ($urandom_range(5) != 0)
                begin
                    it.a = CORNER_W'($urandom_range(63));
                    it.b = CORNER_W'($urandom_range(63));
                    it.c = CORNER_W'($urandom_range(63));
                end
            end
            else if (pick < 60)
                it.kind = FUNC_NONE;
            pending_items.push_back(it);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // tetrahedron plus degenerate, parallel and bad-corner faces
        calm = 1;
        pending_items.push_back(make_item(FUNC_VERTEX, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_VERTEX, 1, 16384, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_VERTEX, 2, 0, 16384, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_VERTEX, 3, 0, 0, 16384, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_VERTEX, 4, -24'sd8388608, 24'sd8388607,
                                          -24'sd1, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_VERTEX, 1024, 5, 5, 5, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_VERTEX, 2047, -1, -1, -1, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_TRIANGLE, 0, 0, 0, 0, 0, 1, 2));
        pending_items.push_back(make_item(FUNC_TRIANGLE, 1, 0, 0, 0, 0, 1, 3));
        pending_items.push_back(make_item(FUNC_TRIANGLE, 2, 0, 0, 0, 0, 2, 3));
        pending_items.push_back(make_item(FUNC_TRIANGLE, 3, 0, 0, 0, 1, 2, 3));
        pending_items.push_back(make_item(FUNC_TRIANGLE, 4, 0, 0, 0, 0, 0, 1));
        pending_items.push_back(make_item(FUNC_TRIANGLE, 5, 0, 0, 0, 0, 1, 1023));
        pending_items.push_back(make_item(FUNC_TRIANGLE, 6, 0, 0, 0, 4, 2, 3));
        pending_items.push_back(make_item(FUNC_TRIANGLE, 2047, 0, 0, 0, 1023, 1023, 1023));
        pending_items.push_back(make_item(FUNC_NONE, 2047, -1, -1, -1, 1023, 1023, 1023));
        write_reg(REG_VERTEX_COUNT, 12'd5);
        write_reg(REG_FACE_COUNT, 12'd7);
        pending_items.push_back(make_item(FUNC_QUERY, 0, 1024, 1024, 1024, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_QUERY, 0, -4096, 1024, 1024, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_QUERY, 0, -4096, 0, 8192, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_QUERY, 2047, 24'sd8388607, -24'sd8388608,
                                          24'sd8388607, 0, 0, 0));
        pending_items.push_back(make_item(FUNC_QUERY, 0, -24'sd8388608, 24'sd8388607,
                                          -24'sd8388608, 0, 0, 0));
        write_reg(REG_VERTEX_COUNT, 12'd0);
        pending_items.push_back(make_item(FUNC_QUERY, 0, 1024, 1024, 1024, 0, 0, 0));

        // a small random mesh that every random phase may read
        for (int i = 0; i < 64; i++)
        begin
            pending_items.push_back(make_item(FUNC_VERTEX, i, rand_coord(), rand_coord(),
                                              rand_coord(), 0, 0, 0));
            pending_items.push_back(make_item(FUNC_TRIANGLE, i, 0, 0, 0, $urandom_range(63),
                                              $urandom_range(63), $urandom_range(63)));
        end

        random_phase(27, 64, 64);
        calm = 0;
        random_phase(27, 17, 33);
        drain();
        // hold the result side so the queue fills and full rises
        hold_pop = 400;
        random_phase(27, 64, 1);
        random_phase(13, 3, 64);
        // pause the sender partway until every result in flight has come back
        while (pending_items.size() > 7)
            @(posedge clk);
        hold_send = 1;
        while (expected_parity.size() > 0)
            @(posedge clk);
        hold_send = 0;
        random_phase(13, 64, 0);
        random_phase(27, 40, 50);

        // vertex count past the end of the store
        calm = 1;
        write_reg(REG_VERTEX_COUNT, 12'd2047);
        write_reg(REG_FACE_COUNT, 12'd64);
        for (int i = 0; i < 3; i++)
            pending_items.push_back(make_item(FUNC_QUERY, 0, rand_coord(), rand_coord(),
                                              rand_coord(), 0, 0, 0));
        write_reg(REG_VERTEX_COUNT, 12'd1024);
        pending_items.push_back(make_item(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0));

        drain();
        if (errors == 0)
            $display("point_in_mesh_ray_parity: match");
        else
            $display("point_in_mesh_ray_parity: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("point_in_mesh_ray_parity: mismatch");
        $finish;
    end

endmodule
